FILE: src/nga_pkg.sv
// Shared types and constants for the multichannel noise gate.
// Used by every design module of the block; has no dependencies of its own.
`default_nettype none

package nga_pkg;

    localparam int DATA_W   = 16;
    localparam int CH_W     = 3;
    localparam int MASK_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [DATA_W-1:0] GAIN_ONE   = 16'h8000;
    localparam logic [DATA_W-1:0] GAIN_RESET = 16'd1638;
    localparam logic [DATA_W-1:0] HOLD_MAX   = 16'hFFFF;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MUTE_MASK   = 3'd0;
    localparam logic [2:0] REG_ACTIVE_MASK = 3'd1;
    localparam logic [2:0] REG_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_FLOOR_GAIN  = 3'd3;
    localparam logic [2:0] REG_HOLD        = 3'd4;
    localparam logic [2:0] REG_ATTACK      = 3'd5;
    localparam logic [2:0] REG_RELEASE     = 3'd6;

    typedef enum logic [PHASE_W-1:0] {
        PH_CLOSED  = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_OPEN    = 3'd2,
        PH_HOLD    = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [DATA_W-1:0]   gain;
        logic [DATA_W-1:0]   hold;
    } gate_state_t;

    localparam gate_state_t STATE_RESET = '{phase: PH_CLOSED, gain: GAIN_RESET, hold: '0};

    typedef struct packed {
        logic [MASK_W-1:0] mute_mask;
        logic [MASK_W-1:0] active_mask;
        logic [DATA_W-1:0] threshold_level;
        logic [DATA_W-1:0] floor_gain;
        logic [DATA_W-1:0] hold_samples;
        logic [DATA_W-1:0] attack_step;
        logic [DATA_W-1:0] release_step;
    } gate_cfg_t;

endpackage

`default_nettype wire

FILE: src/noise_gate_attack_hold_release_top.sv
// Top level of the multichannel noise gate: stream ports, state memory,
// gate step and output register. Depends on nga_pkg, nga_cfg_regs, nga_state_mem and nga_gate_update.
`default_nettype none

// Multichannel noise gate with attack, hold and release per channel. An item
// (channel, Q1.15 sample) is taken every cycle the output side keeps up; its
// result passes a stage register and the output register. The channel's phase,
// gain and hold count are read from the state memory at acceptance through a
// registered read, updated and multiplied in the next cycle and, when active,
// written back at the edge where the result moves into the output register;
// an item that follows on the same channel takes the written-back state through
// a bypass. Reset marks all entries as never written, which reads as closed,
// gain 1638, count zero, so the block takes items right after reset. The user
// must write settings via APB while no item is in flight; the block won't check.
module noise_gate_attack_hold_release_top #(
    parameter int CHANNELS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: [2:0] channel, [18:3] sample_in, [23:19] zero
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [nga_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [2:0] channel_out, [18:3] sample_out, [21:19] gate_phase, [23:22] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [nga_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nga_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [nga_pkg::PDATA_W-1:0]   pwdata,
    output logic      [nga_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    nga_pkg::gate_cfg_t   cfg;
    nga_pkg::gate_state_t rd_state;
    nga_pkg::gate_state_t upd_state;
    nga_pkg::phase_t      phase_out;
    logic [15:0]          sample_out;
    logic                 upd_wr;

    logic                 s1_vld_reg;
    logic [2:0]           s1_ch_reg;
    logic [15:0]          s1_sample_reg;
    logic                 m_vld_reg;
    logic [nga_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [nga_pkg::M_TDATA_W-1:0] m_data_next;

    logic                 accept;
    logic                 advance;
    logic                 mem_wr;

    assign advance  = !m_vld_reg || m_tready;
    assign s_tready = !s1_vld_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign mem_wr   = s1_vld_reg && advance && upd_wr;

    nga_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nga_state_mem #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (AW'(s_tdata[2:0])),
        .wr_en   (mem_wr),
        .wr_addr (AW'(s1_ch_reg)),
        .wr_data (upd_state),
        .rd_data (rd_state)
    );

    nga_gate_update #(
        .CHANNELS (CHANNELS)
    ) u_upd (
        .channel    (s1_ch_reg),
        .sample_in  (s1_sample_reg),
        .cur        (rd_state),
        .cfg        (cfg),
        .upd        (upd_state),
        .wr_en      (upd_wr),
        .sample_out (sample_out),
        .phase_out  (phase_out)
    );

    assign m_data_next = {2'b00, phase_out, sample_out, s1_ch_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_vld_reg <= 1'b1;
            end else if (advance) begin
                s1_vld_reg <= 1'b0;
            end
            if (advance) begin
                m_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ch_reg     <= s_tdata[2:0];
            s1_sample_reg <= s_tdata[18:3];
        end
        if (advance && s1_vld_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

FILE: src/nga_cfg_regs.sv
// Configuration register bank of the noise gate, APB-style write and read.
// Depends on nga_pkg for register indexes and the settings struct.
`default_nettype none

module nga_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nga_pkg::PADDR_W-1:0] paddr,
    input  wire logic [nga_pkg::PDATA_W-1:0] pwdata,
    output logic      [nga_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output nga_pkg::gate_cfg_t               cfg
);

    nga_pkg::gate_cfg_t cfg_reg;
    logic [2:0]         reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mute_mask       <= '0;
            cfg_reg.active_mask     <= '0;
            cfg_reg.threshold_level <= 16'd22938;
            cfg_reg.floor_gain      <= nga_pkg::GAIN_RESET;
            cfg_reg.hold_samples    <= 16'd350;
            cfg_reg.attack_step     <= 16'd65;
            cfg_reg.release_step    <= 16'd65;
        end else if (wr_en) begin
            case (reg_idx)
                nga_pkg::REG_MUTE_MASK:   cfg_reg.mute_mask       <= pwdata[7:0];
                nga_pkg::REG_ACTIVE_MASK: cfg_reg.active_mask     <= pwdata[7:0];
                nga_pkg::REG_THRESHOLD:   cfg_reg.threshold_level <= pwdata[15:0];
                nga_pkg::REG_FLOOR_GAIN:  cfg_reg.floor_gain      <= pwdata[15:0];
                nga_pkg::REG_HOLD:        cfg_reg.hold_samples    <= pwdata[15:0];
                nga_pkg::REG_ATTACK:      cfg_reg.attack_step     <= pwdata[15:0];
                nga_pkg::REG_RELEASE:     cfg_reg.release_step    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nga_pkg::REG_MUTE_MASK:   prdata = {24'd0, cfg_reg.mute_mask};
            nga_pkg::REG_ACTIVE_MASK: prdata = {24'd0, cfg_reg.active_mask};
            nga_pkg::REG_THRESHOLD:   prdata = {16'd0, cfg_reg.threshold_level};
            nga_pkg::REG_FLOOR_GAIN:  prdata = {16'd0, cfg_reg.floor_gain};
            nga_pkg::REG_HOLD:        prdata = {16'd0, cfg_reg.hold_samples};
            nga_pkg::REG_ATTACK:      prdata = {16'd0, cfg_reg.attack_step};
            nga_pkg::REG_RELEASE:     prdata = {16'd0, cfg_reg.release_step};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/nga_state_mem.sv
// Per-channel gate state memory: one write port, one registered read port,
// valid bits for reset and a write-to-read bypass. Depends on nga_pkg.
`default_nettype none

module nga_state_mem #(
    parameter int CHANNELS = 8,
    parameter int AW       = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire nga_pkg::gate_state_t  wr_data,
    output nga_pkg::gate_state_t       rd_data
);

    nga_pkg::gate_state_t mem_reg [CHANNELS];
    nga_pkg::gate_state_t rd_q_reg;
    nga_pkg::gate_state_t fwd_data_reg;
    logic [CHANNELS-1:0]  valid_reg;
    logic                 fwd_reg;
    logic                 vld_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= mem_reg[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                // take the data being written this edge, memory still holds the old one
                fwd_reg   <= wr_en && (wr_addr == rd_addr);
                vld_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = fwd_reg   ? fwd_data_reg :
                     vld_q_reg ? rd_q_reg     : nga_pkg::STATE_RESET;

endmodule

`default_nettype wire

FILE: src/nga_gate_update.sv
// Gate step for one item: ramp or hold count, threshold compare, gain multiply,
// mute and bypass selection. Depends on nga_pkg.
`default_nettype none

module nga_gate_update #(
    parameter int CHANNELS = 8
) (
    input  wire logic [nga_pkg::CH_W-1:0]   channel,
    input  wire logic [nga_pkg::DATA_W-1:0] sample_in,
    input  wire nga_pkg::gate_state_t       cur,
    input  wire nga_pkg::gate_cfg_t         cfg,
    output nga_pkg::gate_state_t            upd,
    output logic                            wr_en,
    output logic [nga_pkg::DATA_W-1:0]      sample_out,
    output nga_pkg::phase_t                 phase_out
);

    logic                   in_range;
    logic [16:0]            mag;
    logic [16:0]            sx;
    logic [15:0]            fl;
    logic [16:0]            g;
    logic [15:0]            hc;
    nga_pkg::phase_t        ph;
    logic signed [32:0]     prod;
    logic [15:0]            scaled;

    // next phase, gain and hold count of the channel
    always_comb begin
        sx       = {sample_in[15], sample_in};
        mag      = sample_in[15] ? 17'(-sx) : sx;
        fl       = (cfg.floor_gain > nga_pkg::GAIN_ONE) ? nga_pkg::GAIN_ONE : cfg.floor_gain;

        ph = cur.phase;
        g  = {1'b0, cur.gain};
        hc = cur.hold;

        case (ph)
            nga_pkg::PH_ATTACK: begin
                g = g + {1'b0, cfg.attack_step};
                if (g >= {1'b0, nga_pkg::GAIN_ONE}) begin
                    g  = {1'b0, nga_pkg::GAIN_ONE};
                    ph = nga_pkg::PH_OPEN;
                end
            end
            nga_pkg::PH_HOLD: begin
                if (hc != nga_pkg::HOLD_MAX) begin
                    hc = hc + 16'd1;
                end
                if (hc >= cfg.hold_samples) begin
                    ph = nga_pkg::PH_RELEASE;
                end
            end
            nga_pkg::PH_RELEASE: begin
                // stop at the floor, even if the floor lies above the gain
                if (g[15:0] <= fl || (g[15:0] - fl) <= cfg.release_step) begin
                    g  = {1'b0, fl};
                    ph = nga_pkg::PH_CLOSED;
                end else begin
                    g = g - {1'b0, cfg.release_step};
                end
            end
            default: ;
        endcase

        if (mag >= {1'b0, cfg.threshold_level}) begin
            if (ph == nga_pkg::PH_CLOSED || ph == nga_pkg::PH_RELEASE) begin
                ph = nga_pkg::PH_ATTACK;
            end else if (ph == nga_pkg::PH_HOLD) begin
                hc = '0;
            end
        end else if (ph == nga_pkg::PH_OPEN) begin
            hc = '0;
            ph = nga_pkg::PH_HOLD;
        end

        upd.phase = ph;
        upd.gain  = g[15:0];
        upd.hold  = hc;
    end

    // result of the item and write-back enable
    always_comb begin
        in_range = 32'(channel) < CHANNELS;

        // floor of (sample * gain) / 2^15
        prod   = $signed({{17{sample_in[15]}}, sample_in}) * $signed({16'd0, g});
        scaled = prod[30:15];

        wr_en = 1'b0;
        if (!in_range) begin
            sample_out = sample_in;
            phase_out  = nga_pkg::PH_CLOSED;
        end else if (cfg.mute_mask[channel]) begin
            sample_out = '0;
            phase_out  = cur.phase;
        end else if (!cfg.active_mask[channel]) begin
            sample_out = sample_in;
            phase_out  = cur.phase;
        end else begin
            sample_out = scaled;
            phase_out  = ph;
            wr_en      = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: src/nga_checker.sv
// Port-level checks for the noise gate top level, attached by bind.
// Depends on noise_gate_attack_hold_release_top's port names only.
`default_nettype none

module nga_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        pready
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled item holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // an empty output register never blocks the input side
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:19] <= 3'd4 && m_tdata[23:22] == 2'b00))
        else $error("bad gate_phase or padding in m_tdata");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind noise_gate_attack_hold_release_top nga_checker u_nga_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the multichannel noise gate: streams (channel, sample) items
// through the block, predicts each gated result and compares it field by field.
// Depends on nga_pkg and noise_gate_attack_hold_release_top.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CH_W        = nga_pkg::CH_W;
    localparam int          DATA_W      = nga_pkg::DATA_W;
    localparam int          MASK_W      = nga_pkg::MASK_W;
    localparam int          PHASE_W     = nga_pkg::PHASE_W;
    localparam int          S_TDATA_W   = nga_pkg::S_TDATA_W;
    localparam int          M_TDATA_W   = nga_pkg::M_TDATA_W;
    localparam int          PADDR_W     = nga_pkg::PADDR_W;
    localparam int          PDATA_W     = nga_pkg::PDATA_W;

    localparam int          NCH         = 8;
    localparam int unsigned UNITY       = nga_pkg::GAIN_ONE;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned SOAK_LEN    = 20;
    localparam int unsigned LONG_STALL  = 400;

    // Per-channel gate predictor and store of gated results still owed by the block.
    class gate_tracker;
        typedef struct {
            logic [CH_W-1:0]   ch;
            logic [DATA_W-1:0] smp;
            nga_pkg::phase_t   ph;
        } gated_t;

        logic [MASK_W-1:0] mute_bits;
        logic [MASK_W-1:0] active_bits;
        int unsigned       threshold;
        int unsigned       floor_lvl;
        int unsigned       hold_len;
        int unsigned       attack_inc;
        int unsigned       release_dec;
        nga_pkg::phase_t   phase_of [NCH];
        int unsigned       gain_of  [NCH];
        int unsigned       count_of [NCH];
        gated_t            gated_q  [$];
        int unsigned       mismatches;
        int unsigned       seen;
        int unsigned       taken;

        function new();
            mute_bits   = '0;
            active_bits = '0;
            threshold   = 22938;
            floor_lvl   = 1638;
            hold_len    = 350;
            attack_inc  = 65;
            release_dec = 65;
            for (int c = 0; c < NCH; c++) begin
                phase_of[c] = nga_pkg::PH_CLOSED;
                gain_of[c]  = nga_pkg::GAIN_RESET;
                count_of[c] = 0;
            end
            mismatches = 0;
            seen       = 0;
            taken      = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [DATA_W-1:0] v);
            case (idx)
                nga_pkg::REG_MUTE_MASK:   mute_bits   = v[MASK_W-1:0];
                nga_pkg::REG_ACTIVE_MASK: active_bits = v[MASK_W-1:0];
                nga_pkg::REG_THRESHOLD:   threshold   = v;
                nga_pkg::REG_FLOOR_GAIN:  floor_lvl   = v;
                nga_pkg::REG_HOLD:        hold_len    = v;
                nga_pkg::REG_ATTACK:      attack_inc  = v;
                nga_pkg::REG_RELEASE:     release_dec = v;
                default: ;
            endcase
        endfunction

        function void take_sample(logic [CH_W-1:0] ch, logic [DATA_W-1:0] raw);
            int              s;
            int unsigned     mag;
            int unsigned     fl;
            int unsigned     g;
            int unsigned     hc;
            nga_pkg::phase_t ph;
            longint          prod;
            gated_t          r;
            s   = int'($signed(raw));
            mag = (s < 0) ? -s : s;
            fl  = (floor_lvl > UNITY) ? UNITY : floor_lvl;
            ph  = phase_of[ch];
            taken++;
            r.ch = ch;
            r.ph = ph;
            if (mute_bits[ch]) begin
                r.smp = '0;
            end else if (!active_bits[ch]) begin
                r.smp = raw;
            end else begin
                g  = gain_of[ch];
                hc = count_of[ch];
                // stored phase acts first
                case (ph)
                    nga_pkg::PH_ATTACK: begin
                        g = g + attack_inc;
                        if (g >= UNITY) begin
                            g  = UNITY;
                            ph = nga_pkg::PH_OPEN;
                        end
                    end
                    nga_pkg::PH_HOLD: begin
                        if (hc < nga_pkg::HOLD_MAX) hc++;
                        if (hc >= hold_len) ph = nga_pkg::PH_RELEASE;
                    end
                    nga_pkg::PH_RELEASE: begin
                        // snap to floor, even upward, once the step would reach it
                        if (g <= fl || g - fl <= release_dec) begin
                            g  = fl;
                            ph = nga_pkg::PH_CLOSED;
                        end else begin
                            g = g - release_dec;
                        end
                    end
                    default: ;
                endcase
                if (mag >= threshold) begin
                    if (ph == nga_pkg::PH_CLOSED || ph == nga_pkg::PH_RELEASE) begin
                        ph = nga_pkg::PH_ATTACK;
                    end else if (ph == nga_pkg::PH_HOLD) begin
                        hc = 0;
                    end
                end else if (ph == nga_pkg::PH_OPEN) begin
                    hc = 0;
                    ph = nga_pkg::PH_HOLD;
                end
                phase_of[ch] = ph;
                gain_of[ch]  = g;
                count_of[ch] = hc;
                prod  = longint'(s) * longint'(g);
                r.smp = DATA_W'(prod >>> 15);
                r.ph  = ph;
            end
            gated_q.push_back(r);
        endfunction

        function void check_gated(logic [M_TDATA_W-1:0] word);
            gated_t             want;
            logic [CH_W-1:0]    ch;
            logic [DATA_W-1:0]  smp;
            logic [PHASE_W-1:0] ph;
            ch  = word[CH_W-1:0];
            smp = word[CH_W +: DATA_W];
            ph  = word[CH_W+DATA_W +: PHASE_W];
            seen++;
            if (gated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ch %0d sample %h phase %0d", ch, smp, ph);
                return;
            end
            want = gated_q.pop_front();
            if (ch !== want.ch || smp !== want.smp || ph !== want.ph) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected ch %0d sample %h phase %0d, ",
                              "got ch %0d sample %h phase %0d"},
                             seen, want.ch, want.smp, want.ph, ch, smp, ph);
            end
        endfunction

        function int unsigned pending();
            return gated_q.size();
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: [2:0] channel, [18:3] sample_in, [23:19] zero
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: [2:0] channel_out, [18:3] sample_out, [21:19] gate_phase, [23:22] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    gate_tracker gate = new();

    int unsigned src_idle_pct    = 0;
    int unsigned snk_stall_pct   = 0;
    bit          long_stall_req  = 1'b0;
    bit          long_stall_done = 1'b0;
    int unsigned long_stall_left = 0;
    int unsigned cycles          = 0;

    noise_gate_attack_hold_release_top #(.CHANNELS(NCH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) gate.take_sample(s_tdata[CH_W-1:0], s_tdata[CH_W +: DATA_W]);
            if (m_tvalid && m_tready) gate.check_gated(m_tdata);
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (long_stall_req && !long_stall_done) begin
            long_stall_done = 1'b1;
            long_stall_left = LONG_STALL;
        end
        if (long_stall_left > 0) begin
            long_stall_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    task automatic send(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] smp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-CH_W-DATA_W){1'b0}}, smp, ch};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic settle();
        s_tvalid = 1'b0;
        while (gate.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = PDATA_W'(val);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        gate.set_register(idx, val);
    endtask

    task automatic configure(input logic [MASK_W-1:0] mute, input logic [MASK_W-1:0] active,
                             input int unsigned thr, input int unsigned fl,
                             input int unsigned hold, input int unsigned atk,
                             input int unsigned rel);
        settle();
        write_reg(nga_pkg::REG_MUTE_MASK,   DATA_W'(mute));
        write_reg(nga_pkg::REG_ACTIVE_MASK, DATA_W'(active));
        write_reg(nga_pkg::REG_THRESHOLD,   DATA_W'(thr));
        write_reg(nga_pkg::REG_FLOOR_GAIN,  DATA_W'(fl));
        write_reg(nga_pkg::REG_HOLD,        DATA_W'(hold));
        write_reg(nga_pkg::REG_ATTACK,      DATA_W'(atk));
        write_reg(nga_pkg::REG_RELEASE,     DATA_W'(rel));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
            default: begin src_idle_pct = 8; snk_stall_pct = 8; end
        endcase
    endtask

    // Sample at or above the current threshold or below it, random sign.
    function automatic logic [DATA_W-1:0] pick_level(input bit loud);
        int unsigned thr;
        int unsigned mag;
        thr = gate.threshold;
        if (thr > UNITY || (!loud && thr == 0)) return DATA_W'($urandom);
        if (loud) mag = $urandom_range(UNITY, thr);
        else      mag = $urandom_range(thr - 1, 0);
        if (mag == UNITY) return 16'h8000;
        return $urandom_range(0, 1) ? DATA_W'(-int'(mag)) : DATA_W'(mag);
    endfunction

    // Runs of loud or quiet samples on one channel, with some noise mixed in.
    task automatic run_phase(input int unsigned n, input int unsigned pause_at);
        logic [CH_W-1:0] ch;
        int unsigned     run_left;
        bit              loud;
        ch       = '0;
        run_left = 0;
        loud     = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) settle();
            if ($urandom_range(0, 9) == 0) begin
                send(CH_W'($urandom), DATA_W'($urandom));
            end else begin
                if (run_left == 0) begin
                    ch       = CH_W'($urandom_range(0, NCH - 1));
                    loud     = ($urandom_range(0, 99) < 40);
                    run_left = $urandom_range(1, 8);
                end
                run_left--;
                send(ch, pick_level(loud));
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // ch1 muted, ch2 bypassed, ch5 muted and bypassed
        configure(8'h22, 8'hDB, 16384, 1000, 2, 20000, 20000);
        send(3'd0, 16'h7FFF);
        send(3'd0, 16'h8000);
        send(3'd0, 16'h4000);
        send(3'd0, 16'h3FFF);
        send(3'd0, 16'h0000);
        send(3'd0, 16'hC000);
        send(3'd0, 16'h0001);
        send(3'd0, 16'hFFFF);
        send(3'd0, 16'h0000);
        send(3'd0, 16'h0000);
        send(3'd0, 16'h0000);
        send(3'd0, 16'h0000);
        send(3'd1, 16'h7FFF);
        send(3'd2, 16'h8000);
        send(3'd5, 16'h3039);
        send(3'd7, 16'h8000);
        send(3'd7, 16'h5555);
        send(3'd7, 16'hAAAA);
        send(3'd7, 16'h7FFF);
        send(3'd3, 16'h8001);
        send(3'd4, 16'h1234);
        send(3'd6, 16'hEDCB);

        for (int p = 0; p < 8; p++) begin
            set_idling(p % 4);
            case (p)
                0: configure(8'h00, 8'hFF, 12000, 1638, 4, 6000, 5000);
                1: configure(8'h00, 8'h00, 0, 0, 0, 0, 0);
                2: configure(8'h00, 8'hFF, 65535, 40000, 65535, 32768, 32768);
                3: configure(8'h00, 8'hFF, 32768, 32768, 1, 32768, 1);
                4: configure(8'h00, 8'hFF, 0, 0, 0, 0, 0);
                6: configure(8'hFF, 8'($urandom), $urandom_range(2000, 30000),
                             $urandom_range(0, 6000), $urandom_range(0, 6),
                             $urandom_range(1500, 20000), $urandom_range(1500, 20000));
                default: configure(8'($urandom) & 8'($urandom), 8'($urandom) | 8'($urandom),
                                   $urandom_range(2000, 30000), $urandom_range(0, 6000),
                                   $urandom_range(0, 6), $urandom_range(1500, 20000),
                                   $urandom_range(1500, 20000));
            endcase
            if (p == 0) long_stall_req = 1'b1;
            run_phase(100, (p == 0) ? 60 : 1000);
        end

        // Open one channel, hold it through a longer count, then let it release.
        set_idling(0);
        configure(8'h00, 8'h08, 16384, 1638, 12, 32768, 32768);
        repeat (3) send(3'd3, 16'h7FFF);
        repeat (SOAK_LEN) send(3'd3, 16'h0100);

        settle();
        repeat (8) @(negedge aclk);
        $display("Noise gate run: %0d items in, %0d results checked, %0d mismatches.",
                 gate.taken, gate.seen, gate.mismatches);
        $display("Covered mute and bypass, all gate phases, setting extremes, hold to release, "
                 , "four idling mixes and a long output stall.");
        if (gate.mismatches == 0 && gate.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/nga_pkg.sv
src/nga_cfg_regs.sv
src/nga_state_mem.sv
src/nga_gate_update.sv
src/noise_gate_attack_hold_release_top.sv
src/nga_checker.sv
test/tb_top.sv
